[sv/ple_pkg.sv]
// ---------------------------------------------------------------------------
// ple_pkg: shared types and codes for the positional list engine
// Request codes, status codes, internal cell operations and the token that
// travels down the row of storage cells.
// ---------------------------------------------------------------------------
package ple_pkg;

    // default number of storage cells
    localparam int CAPACITY_DEF = 64;

    // index width that covers the largest supported capacity (1024) plus one
    localparam int IDX_W = 11;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // request codes
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSPOS = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SORTED = 3'd2;
    localparam logic [FUNC_W-1:0] FN_HEAD   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TAIL   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // operation carried by the token through the cells
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ = 3'd1;
    localparam logic [OP_W-1:0] OP_INS  = 3'd2;
    localparam logic [OP_W-1:0] OP_SORT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

    // token handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic                active;
        logic [OP_W-1:0]     op;
        logic [IDX_W-1:0]    k;      // target slot, zero based
        logic [IDX_W-1:0]    cnt;    // element count before the request
        logic                found;  // sorted insert has started shifting
        logic [DATA_W-1:0]   carry;  // value moving up the row
        logic [DATA_W-1:0]   rdata;  // element read or removed
        logic [STATUS_W-1:0] st;
        logic [IDX_W-1:0]    len;    // element count after the request
    } tok_t;

endpackage

[sv/ple_cell.sv]
// ---------------------------------------------------------------------------
// ple_cell: one storage cell of the list
// Holds one element. When the token passes, the cell shifts its element up,
// takes its right neighbor's element, or reports its element, then hands the
// token on to the next cell.
// ---------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ple_pkg::tok_t              tok_i,
    input  logic [ple_pkg::DATA_W-1:0] next_elem_i,
    output ple_pkg::tok_t              tok_o,
    output logic [ple_pkg::DATA_W-1:0] elem_o
);

    localparam logic [ple_pkg::IDX_W-1:0] IDX_V  = ple_pkg::IDX_W'(IDX);
    localparam logic [ple_pkg::IDX_W-1:0] IDX_V1 = ple_pkg::IDX_W'(IDX + 1);

    logic [ple_pkg::DATA_W-1:0] elem_reg;
    logic [ple_pkg::DATA_W-1:0] elem_next;
    ple_pkg::tok_t              tok_reg;
    ple_pkg::tok_t              tok_next;
    logic                       hit;
    logic                       in_range;

    // per-cell action on the passing token
    always_comb begin
        tok_next  = tok_i;
        elem_next = elem_reg;
        in_range  = (IDX_V <= tok_i.cnt);
        hit       = 1'b0;
        if (tok_i.active) begin
            case (tok_i.op)
                ple_pkg::OP_READ: begin
                    if (IDX_V == tok_i.k) begin
                        tok_next.rdata = elem_reg;
                    end
                end
                ple_pkg::OP_INS: begin
                    if (IDX_V >= tok_i.k && in_range) begin
                        elem_next      = tok_i.carry;
                        tok_next.carry = elem_reg;
                    end
                end
                ple_pkg::OP_SORT: begin
                    hit = !tok_i.found && ((IDX_V == tok_i.cnt) ||
                          ((IDX_V < tok_i.cnt) &&
                           ($signed(elem_reg) >= $signed(tok_i.carry))));
                    if ((tok_i.found || hit) && in_range) begin
                        elem_next      = tok_i.carry;
                        tok_next.carry = elem_reg;
                        tok_next.found = 1'b1;
                    end
                end
                ple_pkg::OP_DEL: begin
                    if (IDX_V == tok_i.k) begin
                        tok_next.rdata = elem_reg;
                    end
                    if (IDX_V >= tok_i.k && IDX_V1 < tok_i.cnt) begin
                        elem_next = next_elem_i;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // element storage
    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
    end

    // token hand-off, only the active flag is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg.active <= tok_next.active;
        end
        tok_reg.op    <= tok_next.op;
        tok_reg.k     <= tok_next.k;
        tok_reg.cnt   <= tok_next.cnt;
        tok_reg.found <= tok_next.found;
        tok_reg.carry <= tok_next.carry;
        tok_reg.rdata <= tok_next.rdata;
        tok_reg.st    <= tok_next.st;
        tok_reg.len   <= tok_next.len;
    end

    assign tok_o  = tok_reg;
    assign elem_o = elem_reg;

endmodule

[sv/positional_list_engine_unit.sv]
// ---------------------------------------------------------------------------
// positional_list_engine_unit: ordered list with insert, delete and read
// Flow: the request is decoded into the launch register as it is accepted,
// then the token passes through each storage cell register in turn and on
// into the result register, or into the skid register while the output stalls.
// A new request is taken once the previous token has left the row and the
// skid register is empty; the previous result may still wait at the output.
// Reset: synchronous active-low aresetn empties the list (length zero) and
// clears all handshake state; element contents are left as they are.
// ---------------------------------------------------------------------------
module positional_list_engine_unit #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ple_pkg::FUNC_W-1:0]         s_func,
    input  logic [ple_pkg::POS_W-1:0]          s_position,
    input  logic signed [ple_pkg::DATA_W-1:0]  s_value_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ple_pkg::STATUS_W-1:0]       m_status,
    output logic signed [ple_pkg::DATA_W-1:0]  m_value_out,
    output logic [ple_pkg::LEN_W-1:0]          m_length
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       busy_reg;
    ple_pkg::tok_t              launch_reg;
    ple_pkg::tok_t              launch_next;
    ple_pkg::tok_t              tok_chain [CAPACITY+1];
    logic [ple_pkg::DATA_W-1:0] elem_chain [CAPACITY+1];
    ple_pkg::tok_t              tok_end;

    logic                       accept;
    logic                       full;
    logic                       pos_ok;
    logic                       ins_pos_ok;
    logic [ple_pkg::IDX_W-1:0]  posx;
    logic [ple_pkg::IDX_W-1:0]  cntx;
    logic [ple_pkg::IDX_W-1:0]  posm1;

    logic                       m_valid_reg;
    logic [ple_pkg::STATUS_W-1:0] m_status_reg;
    logic [ple_pkg::DATA_W-1:0] m_value_reg;
    logic [ple_pkg::LEN_W-1:0]  m_length_reg;
    logic                       skid_valid_reg;
    logic [ple_pkg::STATUS_W-1:0] skid_status_reg;
    logic [ple_pkg::DATA_W-1:0] skid_value_reg;
    logic [ple_pkg::LEN_W-1:0]  skid_length_reg;

    logic                       out_free;
    logic                       load_m_skid;
    logic                       load_m_res;
    logic                       load_skid;

    assign s_ready = !busy_reg && !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // request decode and range checks
    assign posx       = ple_pkg::IDX_W'(s_position);
    assign cntx       = ple_pkg::IDX_W'(count_reg);
    assign posm1      = posx - 1'b1;
    assign full       = (count_reg == CW'(CAPACITY));
    assign pos_ok     = (posx != '0) && (posx <= cntx);
    assign ins_pos_ok = (posx != '0) && (posx <= cntx + 1'b1);

    always_comb begin
        launch_next        = '0;
        launch_next.active = 1'b1;
        launch_next.op     = ple_pkg::OP_NONE;
        launch_next.cnt    = cntx;
        launch_next.carry  = s_value_in;
        launch_next.st     = ple_pkg::ST_OK;
        count_next         = count_reg;
        unique case (s_func)
            ple_pkg::FN_READ: begin
                if (pos_ok) begin
                    launch_next.op = ple_pkg::OP_READ;
                    launch_next.k  = posm1;
                end else begin
                    launch_next.st = ple_pkg::ST_BAD;
                end
            end
            ple_pkg::FN_INSPOS: begin
                if (!ins_pos_ok) begin
                    launch_next.st = ple_pkg::ST_BAD;
                end else if (full) begin
                    launch_next.st = ple_pkg::ST_FULL;
                end else begin
                    launch_next.op = ple_pkg::OP_INS;
                    launch_next.k  = posm1;
                    count_next     = count_reg + 1'b1;
                end
            end
            ple_pkg::FN_SORTED: begin
                if (full) begin
                    launch_next.st = ple_pkg::ST_FULL;
                end else begin
                    launch_next.op = ple_pkg::OP_SORT;
                    count_next     = count_reg + 1'b1;
                end
            end
            ple_pkg::FN_HEAD: begin
                if (full) begin
                    launch_next.st = ple_pkg::ST_FULL;
                end else begin
                    launch_next.op = ple_pkg::OP_INS;
                    launch_next.k  = '0;
                    count_next     = count_reg + 1'b1;
                end
            end
            ple_pkg::FN_TAIL: begin
                if (full) begin
                    launch_next.st = ple_pkg::ST_FULL;
                end else begin
                    launch_next.op = ple_pkg::OP_INS;
                    launch_next.k  = cntx;
                    count_next     = count_reg + 1'b1;
                end
            end
            ple_pkg::FN_DELETE: begin
                if (pos_ok) begin
                    launch_next.op = ple_pkg::OP_DEL;
                    launch_next.k  = posm1;
                    count_next     = count_reg - 1'b1;
                end else begin
                    launch_next.st = ple_pkg::ST_BAD;
                end
            end
            default: begin
                launch_next.st = ple_pkg::ST_BAD;
            end
        endcase
        launch_next.len = ple_pkg::IDX_W'(count_next);
    end

    // launch register and list length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launch_reg.active <= 1'b0;
            count_reg         <= '0;
        end else begin
            launch_reg.active <= accept;
            if (accept) begin
                count_reg <= count_next;
            end
        end
        launch_reg.op    <= launch_next.op;
        launch_reg.k     <= launch_next.k;
        launch_reg.cnt   <= launch_next.cnt;
        launch_reg.found <= launch_next.found;
        launch_reg.carry <= launch_next.carry;
        launch_reg.rdata <= launch_next.rdata;
        launch_reg.st    <= launch_next.st;
        launch_reg.len   <= launch_next.len;
    end

    // row of storage cells
    assign tok_chain[0]         = launch_reg;
    assign elem_chain[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        ple_cell #(
            .IDX (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .tok_i       (tok_chain[i]),
            .next_elem_i (elem_chain[i+1]),
            .tok_o       (tok_chain[i+1]),
            .elem_o      (elem_chain[i])
        );
    end

    assign tok_end = tok_chain[CAPACITY];

    // result register with skid stage
    assign out_free    = !m_valid_reg || m_ready;
    assign load_m_skid = out_free && skid_valid_reg;
    assign load_m_res  = out_free && !skid_valid_reg && tok_end.active;
    assign load_skid   = !out_free && tok_end.active;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (tok_end.active) begin
                busy_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= skid_valid_reg || tok_end.active;
            end
            if (load_m_skid) begin
                skid_valid_reg <= 1'b0;
            end else if (load_skid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_m_skid) begin
            m_status_reg <= skid_status_reg;
            m_value_reg  <= skid_value_reg;
            m_length_reg <= skid_length_reg;
        end else if (load_m_res) begin
            m_status_reg <= tok_end.st;
            m_value_reg  <= tok_end.rdata;
            m_length_reg <= tok_end.len[ple_pkg::LEN_W-1:0];
        end
        if (load_skid) begin
            skid_status_reg <= tok_end.st;
            skid_value_reg  <= tok_end.rdata;
            skid_length_reg <= tok_end.len[ple_pkg::LEN_W-1:0];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_value_out = m_value_reg;
    assign m_length    = m_length_reg;

endmodule
